/* sv/tli_pkg.sv */
// ----------------------------------------------------------------------------
// tli_pkg: shared types and constants of the table linear interpolator
// Word formats, item and status codes, datapath widths and the breakpoint
// values that the table holds after reset.
// ----------------------------------------------------------------------------
package tli_pkg;

   localparam int TABLE_POINTS   = 16;
   localparam int PIDX_WIDTH     = $clog2(TABLE_POINTS);
   localparam int PCNT_WIDTH     = $clog2(TABLE_POINTS + 1);
   localparam int CFG_WIDTH      = 5;
   localparam int DATA_WIDTH     = 16;
   localparam int DIFF_WIDTH     = DATA_WIDTH + 1;
   localparam int PROD_WIDTH     = 2 * DIFF_WIDTH;
   localparam int DIVIDEND_WIDTH = PROD_WIDTH;
   localparam int DIV_BITS       = 2;
   localparam int DIV_STEPS      = DIVIDEND_WIDTH / DIV_BITS;
   localparam int DIV_CNT_WIDTH  = $clog2(DIV_STEPS);
   localparam int SUM_WIDTH      = DIVIDEND_WIDTH + 2;
   localparam int PADDR_WIDTH    = 3;
   localparam int PDATA_WIDTH    = 32;

   localparam logic [CFG_WIDTH-1:0] RESET_IN_USE = 5'd14;

   // Register index, taken from the word address bit of paddr.
   localparam logic REG_POINTS_IN_USE = 1'b0;

   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_FORWARD = 2'd1;
   localparam logic [1:0] KIND_INVERSE = 2'd2;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_SATURATED = 2'd1;
   localparam logic [1:0] STS_FLAT      = 2'd2;
   localparam logic [1:0] STS_BAD_INDEX = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic [3:0]         point_index;
      logic signed [15:0] temperature_in;
      logic signed [15:0] viscosity_in;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] value_out;
      logic [1:0]         status;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic search;
      logic fetch;
      logic multiply;
      logic start_div;
      logic finish;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic query;
      logic search_done;
      logic flat;
      logic div_done;
   } ctrl_sts_type;

   function automatic logic signed [DATA_WIDTH-1:0] reset_temperature(
      input logic [PIDX_WIDTH-1:0] idx
   );
      logic signed [DATA_WIDTH-1:0] val;
      case (idx)
         0:       val = 16'sd3840;
         1:       val = 16'sd4096;
         2:       val = 16'sd4352;
         3:       val = 16'sd4608;
         4:       val = 16'sd4864;
         5:       val = 16'sd5120;
         6:       val = 16'sd5376;
         7:       val = 16'sd5632;
         8:       val = 16'sd5888;
         9:       val = 16'sd6144;
         10:      val = 16'sd6400;
         11:      val = 16'sd6656;
         12:      val = 16'sd6912;
         13:      val = 16'sd7168;
         default: val = '0;
      endcase
      return val;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] reset_viscosity(
      input logic [PIDX_WIDTH-1:0] idx
   );
      logic signed [DATA_WIDTH-1:0] val;
      case (idx)
         0:       val = 16'sd4669;
         1:       val = 16'sd4547;
         2:       val = 16'sd4424;
         3:       val = 16'sd4342;
         4:       val = 16'sd4219;
         5:       val = 16'sd4137;
         6:       val = 16'sd4026;
         7:       val = 16'sd3932;
         8:       val = 16'sd3842;
         9:       val = 16'sd3756;
         10:      val = 16'sd3670;
         11:      val = 16'sd3588;
         12:      val = 16'sd3510;
         13:      val = 16'sd3437;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

/* sv/table_linear_interpolator.sv */
// ----------------------------------------------------------------------------
// table_linear_interpolator: piecewise linear lookup over a breakpoint table
// Usage:
// - The req channel takes a word: a point load, a forward query (viscosity
//   at a temperature) or an inverse query (temperature at a viscosity).
// - The rsp channel returns one word for every request word, in order.
// - The block works on one word at a time; req_stall is high while a word is
//   in progress. A load or an unused kind skips the search and goes straight
//   from capture to the output stage.
// - A query walks the table one entry per cycle, then steps through segment
//   fetch, multiply and divider setup, the two-bit-per-cycle divider, then
//   fix-up and output. A flat segment skips the divider and the fix-up.
// - The result sits in an output register: while rsp_stall is high the word
//   holds and the block may finish the next word, then waits for the slot.
// - Reset empties the output and restores the fourteen default breakpoints
//   and a count of 14 points in use at once.
// - The points-in-use register sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module table_linear_interpolator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tli_pkg::req_word_type            req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tli_pkg::rsp_word_type            rsp_word,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tli_pkg::PADDR_WIDTH-1:0]  paddr,
   input  logic [tli_pkg::PDATA_WIDTH-1:0]  pwdata,
   output logic [tli_pkg::PDATA_WIDTH-1:0]  prdata,
   output logic                             pready
);
   import tli_pkg::*;

   logic [CFG_WIDTH-1:0] points_in_use_ff, points_in_use_in;
   logic                 reg_hit;
   ctrl_cmd_type         cmd;
   ctrl_sts_type         sts;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == REG_POINTS_IN_USE);
   assign prdata  = reg_hit ? PDATA_WIDTH'(points_in_use_ff) : '0;

   always_comb begin
      points_in_use_in = points_in_use_ff;
      if (psel && penable && pwrite && reg_hit) begin
         points_in_use_in = pwdata[CFG_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_in_use_ff <= RESET_IN_USE;
      end else begin
         points_in_use_ff <= points_in_use_in;
      end
   end

   tli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   tli_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_word      (req_word),
      .points_in_use (points_in_use_ff),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_word      (rsp_word)
   );

endmodule

/* sv/tli_div.sv */
// ----------------------------------------------------------------------------
// tli_div: iterative unsigned divider
// Restoring division that retires two quotient bits per cycle. The dividend
// shifts out at the top while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module tli_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [tli_pkg::DIVIDEND_WIDTH-1:0]  dividend,
   input  logic [tli_pkg::DATA_WIDTH-1:0]      divisor,
   output logic                                done,
   output logic [tli_pkg::DIVIDEND_WIDTH-1:0]  quotient
);
   import tli_pkg::*;

   logic                      busy_ff, busy_in;
   logic [DIV_CNT_WIDTH-1:0]  count_ff, count_in;
   logic [DATA_WIDTH-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_WIDTH-1:0] quo_ff, quo_in;

   always_comb begin
      logic [DATA_WIDTH:0] trial;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial  = {rem_in, quo_in[DIVIDEND_WIDTH-1]};
         quo_in = {quo_in[DIVIDEND_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in    = DATA_WIDTH'(trial - {1'b0, divisor});
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial[DATA_WIDTH-1:0];
         end
      end
   end

   assign done     = busy_ff && (count_ff == '0);
   assign quotient = quo_ff;

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = DIV_CNT_WIDTH'(DIV_STEPS - 1);
      end else if (busy_ff) begin
         busy_in  = (count_ff != '0);
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule

/* sv/tli_dpath.sv */
// ----------------------------------------------------------------------------
// tli_dpath: breakpoint table, segment search and interpolation datapath
// Holds the breakpoint memories, walks the table one entry per cycle,
// multiplies the segment differences and drives the divider and the output
// word register under command of the controller.
// ----------------------------------------------------------------------------
module tli_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  tli_pkg::req_word_type          req_word,
   input  logic [tli_pkg::CFG_WIDTH-1:0]  points_in_use,
   input  tli_pkg::ctrl_cmd_type          cmd,
   output tli_pkg::ctrl_sts_type          sts,
   output tli_pkg::rsp_word_type          rsp_word
);
   import tli_pkg::*;

   // Breakpoint memories; an entry not yet loaded reads as its reset point.
   logic [DATA_WIDTH-1:0]    temp_mem [TABLE_POINTS];
   logic [DATA_WIDTH-1:0]    visc_mem [TABLE_POINTS];
   logic [TABLE_POINTS-1:0]  valid_ff;

   logic [DATA_WIDTH-1:0]    rd_temp_ff, rd_visc_ff;
   logic                     rd_valid_ff;
   logic [PIDX_WIDTH-1:0]    rd_addr_ff;
   logic signed [DATA_WIDTH-1:0] rd_temp, rd_visc;

   logic [PIDX_WIDTH-1:0]    idx_ff, idx_in;
   logic                     dir_inv_ff;
   logic signed [DATA_WIDTH-1:0] q_ff;
   logic signed [DATA_WIDTH-1:0] a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [DIFF_WIDTH-1:0] den_ff, den_in;
   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic                     neg_ff;
   logic signed [DATA_WIDTH-1:0] res_value_ff;
   logic [1:0]               res_status_ff;
   rsp_word_type             out_word_ff;

   logic [PCNT_WIDTH-1:0]    n_eff;
   logic [PIDX_WIDTH-1:0]    last_idx, start_inv;
   logic signed [DATA_WIDTH-1:0] key, other;
   logic                     at_end, search_more;
   logic                     bad_index, mem_we;
   logic [PIDX_WIDTH-1:0]    waddr;

   logic [DIVIDEND_WIDTH-1:0] mag_n, dividend, quotient;
   logic [DIFF_WIDTH-1:0]     mag_d;
   logic                      flat, div_start, div_done;
   logic signed [SUM_WIDTH-1:0] signed_quo, sum;
   logic signed [DATA_WIDTH-1:0] fix_value;
   logic [1:0]                fix_status;

   // Effective point count, clamped to the table.
   always_comb begin
      if (32'(points_in_use) < 2) begin
         n_eff = PCNT_WIDTH'(2);
      end else if (32'(points_in_use) > TABLE_POINTS) begin
         n_eff = PCNT_WIDTH'(TABLE_POINTS);
      end else begin
         n_eff = PCNT_WIDTH'(points_in_use);
      end
      last_idx  = PIDX_WIDTH'(n_eff - PCNT_WIDTH'(1));
      start_inv = PIDX_WIDTH'(n_eff - PCNT_WIDTH'(2));
   end

   assign rd_temp = rd_valid_ff ? $signed(rd_temp_ff) : reset_temperature(rd_addr_ff);
   assign rd_visc = rd_valid_ff ? $signed(rd_visc_ff) : reset_viscosity(rd_addr_ff);

   // The search key is temperature going up, viscosity going down.
   always_comb begin
      key         = dir_inv_ff ? rd_visc : rd_temp;
      other       = dir_inv_ff ? rd_temp : rd_visc;
      at_end      = dir_inv_ff ? (idx_ff == '0) : (idx_ff == last_idx);
      search_more = !at_end && (key < q_ff);
   end

   assign bad_index = 32'(req_word.point_index) >= TABLE_POINTS;
   assign mem_we    = cmd.capture && (req_word.kind == KIND_LOAD) && !bad_index;
   assign waddr     = PIDX_WIDTH'(req_word.point_index);

   // The memory is always read at the next index, so the registered read
   // data belongs to the current index.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.capture) begin
         idx_in = (req_word.kind == KIND_INVERSE) ? start_inv : PIDX_WIDTH'(1);
      end else if (cmd.search) begin
         if (search_more == dir_inv_ff) begin
            idx_in = idx_ff - 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      den_in  = DIFF_WIDTH'(a2_ff) - DIFF_WIDTH'(a1_ff);
      prod_in = PROD_WIDTH'(DIFF_WIDTH'(b2_ff) - DIFF_WIDTH'(b1_ff))
              * PROD_WIDTH'(DIFF_WIDTH'(q_ff) - DIFF_WIDTH'(a1_ff));
   end

   always_comb begin
      flat      = (den_ff == '0);
      mag_n     = prod_ff[PROD_WIDTH-1] ? DIVIDEND_WIDTH'(-prod_ff)
                                        : DIVIDEND_WIDTH'(prod_ff);
      mag_d     = den_ff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-den_ff) : DIFF_WIDTH'(den_ff);
      dividend  = mag_n + DIVIDEND_WIDTH'(mag_d >> 1);
      div_start = cmd.start_div && !flat;
   end

   tli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (mag_d[DATA_WIDTH-1:0]),
      .done     (div_done),
      .quotient (quotient)
   );

   // Apply the sign, add the base point and clamp to 16 bits.
   always_comb begin
      signed_quo = neg_ff ? -$signed(SUM_WIDTH'(quotient)) : $signed(SUM_WIDTH'(quotient));
      sum        = signed_quo + SUM_WIDTH'(b1_ff);
      if (sum > SUM_WIDTH'(32767)) begin
         fix_value  = 16'sh7FFF;
         fix_status = STS_SATURATED;
      end else if (sum < SUM_WIDTH'(-32768)) begin
         fix_value  = 16'sh8000;
         fix_status = STS_SATURATED;
      end else begin
         fix_value  = sum[DATA_WIDTH-1:0];
         fix_status = STS_OK;
      end
   end

   always_comb begin
      sts.query       = (req_word.kind == KIND_FORWARD) || (req_word.kind == KIND_INVERSE);
      sts.search_done = !search_more;
      sts.flat        = flat;
      sts.div_done    = div_done;
   end

   assign rsp_word = out_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         temp_mem[waddr] <= req_word.temperature_in;
         visc_mem[waddr] <= req_word.viscosity_in;
      end
      rd_temp_ff  <= temp_mem[idx_in];
      rd_visc_ff  <= visc_mem[idx_in];
      rd_valid_ff <= valid_ff[idx_in];
      rd_addr_ff  <= idx_in;
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.capture) begin
         dir_inv_ff    <= (req_word.kind == KIND_INVERSE);
         q_ff          <= (req_word.kind == KIND_INVERSE) ? req_word.viscosity_in
                                                          : req_word.temperature_in;
         res_value_ff  <= '0;
         res_status_ff <= ((req_word.kind == KIND_LOAD) && bad_index) ? STS_BAD_INDEX
                                                                      : STS_OK;
      end
      if (cmd.search && !search_more) begin
         a2_ff <= key;
         b2_ff <= other;
      end
      if (cmd.fetch) begin
         a1_ff <= key;
         b1_ff <= other;
      end
      if (cmd.multiply) begin
         den_ff  <= den_in;
         prod_ff <= prod_in;
      end
      if (cmd.start_div) begin
         neg_ff <= prod_ff[PROD_WIDTH-1] != den_ff[DIFF_WIDTH-1];
         if (flat) begin
            res_value_ff  <= '0;
            res_status_ff <= STS_FLAT;
         end
      end
      if (cmd.finish) begin
         res_value_ff  <= fix_value;
         res_status_ff <= fix_status;
      end
      if (cmd.out_load) begin
         out_word_ff.value_out <= res_value_ff;
         out_word_ff.status    <= res_status_ff;
      end
   end

endmodule

/* sv/tli_ctrl.sv */
// ----------------------------------------------------------------------------
// tli_ctrl: sequencing state machine of the table linear interpolator
// Takes one word at a time, steps the datapath through search, fetch,
// multiply, divide and fix-up, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module tli_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tli_pkg::ctrl_cmd_type  cmd,
   input  tli_pkg::ctrl_sts_type  sts
);
   import tli_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_FETCH  = 3'd2;
   localparam logic [2:0] S_MULT   = 3'd3;
   localparam logic [2:0] S_PREP   = 3'd4;
   localparam logic [2:0] S_DIV    = 3'd5;
   localparam logic [2:0] S_FIX    = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sts.query ? S_SEARCH : S_DONE;
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            if (sts.search_done) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_MULT;
         end
         S_MULT: begin
            cmd.multiply = 1'b1;
            state_in     = S_PREP;
         end
         S_PREP: begin
            cmd.start_div = 1'b1;
            state_in      = sts.flat ? S_DONE : S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            cmd.finish = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* sv/tli_chk.sv */
// ----------------------------------------------------------------------------
// tli_chk: port-level checks of the table linear interpolator
// Watches the channel ports and the result codes over time.
// ----------------------------------------------------------------------------
module tli_chk (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  tli_pkg::rsp_word_type  rsp_word
);
   import tli_pkg::*;

   // One word is in progress at a time, so taking a word closes the input.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while a word is in progress");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled result dropped or changed");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.status == STS_FLAT)) |-> (rsp_word.value_out == '0))
      else $error("flat segment result is not zero");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.status == STS_SATURATED)) |->
         ((rsp_word.value_out == 16'sh7FFF) || (rsp_word.value_out == 16'sh8000)))
      else $error("saturated result is not at a limit");

endmodule

bind table_linear_interpolator tli_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench for table_linear_interpolator
// A queue of request words feeds a clocked driver with random gaps. A shadow
// breakpoint table predicts every result word, and a clocked monitor compares
// each result word with the oldest prediction. The points-in-use register is
// set over the APB port between phases, including out-of-range counts.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tli_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int LONG_HOLD      = 400;
   localparam int WORDS_PER_SET  = 120;
   localparam int DEFAULT_POINTS = 14;
   localparam int SETTING_COUNT  = 8;

   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [PADDR_WIDTH-1:0] ADDR_POINTS_IN_USE = {REG_POINTS_IN_USE, 2'b00};
   localparam logic [PADDR_WIDTH-1:0] ADDR_UNMAPPED      = {~REG_POINTS_IN_USE, 2'b00};

   // Viscosities after reset, entry 0 in the low 16 bits.
   localparam logic [16*DEFAULT_POINTS-1:0] DEFAULT_VISC = {
      16'd3437, 16'd3510, 16'd3588, 16'd3670, 16'd3756, 16'd3842, 16'd3932,
      16'd4026, 16'd4137, 16'd4219, 16'd4342, 16'd4424, 16'd4547, 16'd4669
   };

   typedef struct {
      req_word_type word;
      bit           wait_empty;
   } queued_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_word_type           req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_word;
   logic                   psel = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite = 1'b0;
   logic [PADDR_WIDTH-1:0] paddr = '0;
   logic [PDATA_WIDTH-1:0] pwdata = '0;
   logic [PDATA_WIDTH-1:0] prdata;
   logic                   pready;

   table_linear_interpolator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Shadow of the block's table and register, advanced as words are taken.
   logic signed [15:0]   shadow_temp [TABLE_POINTS];
   logic signed [15:0]   shadow_visc [TABLE_POINTS];
   logic [CFG_WIDTH-1:0] shadow_in_use;

   // The generator's own view of the table, used to aim operands at segments.
   int                   aim_temp [TABLE_POINTS];
   int                   aim_visc [TABLE_POINTS];

   queued_word_type      queued_words [$];
   rsp_word_type         expected_results [$];

   int unsigned          idle_left = 0;
   int unsigned          tx_quiet = 0;
   int unsigned          stall_left = 0;
   int unsigned          rx_quiet = 0;
   int                   hold_asked = 0;
   int                   hold_done = 0;
   int                   cycle_count = 0;
   int                   mismatches = 0;
   int                   results_checked = 0;
   int                   kind_count [4] = '{0, 0, 0, 0};
   int                   status_count [4] = '{0, 0, 0, 0};
   int                   point_settings [SETTING_COUNT] = '{16, 2, 0, 1, 31, 17, 9, 14};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still expected.",
                  cycle_count, expected_results.size());
         $display("** table_linear_interpolator: FAILED **");
         $finish;
      end
   end

   // b1 + (b2 - b1) * (q - a1) / (a2 - a1), rounded half away from zero.
   function automatic rsp_word_type segment_interp(input longint a1, input longint b1,
                                                   input longint a2, input longint b2,
                                                   input longint q);
      rsp_word_type r;
      longint       den, num, mag_n, mag_d, quo, val;
      bit           neg;
      r = '0;
      den = a2 - a1;
      num = (b2 - b1) * (q - a1);
      if (den == 0) begin
         r.status = STS_FLAT;
         return r;
      end
      neg = (num < 0) != (den < 0);
      mag_n = (num < 0) ? -num : num;
      mag_d = (den < 0) ? -den : den;
      quo = (mag_n + mag_d / 2) / mag_d;
      if (neg) begin
         quo = -quo;
      end
      val = quo + b1;
      if (val > 32767) begin
         r.value_out = 16'sh7fff;
         r.status = STS_SATURATED;
      end else if (val < -32768) begin
         r.value_out = 16'sh8000;
         r.status = STS_SATURATED;
      end else begin
         r.value_out = val[15:0];
         r.status = STS_OK;
      end
      return r;
   endfunction

   function automatic rsp_word_type predict_lookup(input req_word_type w);
      rsp_word_type r;
      int           n, i, t, v;
      r = '0;
      n = shadow_in_use;
      if (n < 2) begin
         n = 2;
      end
      if (n > TABLE_POINTS) begin
         n = TABLE_POINTS;
      end
      t = $signed(w.temperature_in);
      v = $signed(w.viscosity_in);
      case (w.kind)
         KIND_LOAD: begin
            if (w.point_index < TABLE_POINTS) begin
               shadow_temp[w.point_index] = w.temperature_in;
               shadow_visc[w.point_index] = w.viscosity_in;
            end else begin
               r.status = STS_BAD_INDEX;
            end
         end
         KIND_FORWARD: begin
            i = 1;
            while (i < n - 1 && shadow_temp[i] < t) i++;
            r = segment_interp(shadow_temp[i-1], shadow_visc[i-1],
                               shadow_temp[i], shadow_visc[i], t);
         end
         KIND_INVERSE: begin
            // Viscosity falls with the index, so the walk runs downward.
            i = n - 2;
            while (i > 0 && shadow_visc[i] < v) i--;
            r = segment_interp(shadow_visc[i+1], shadow_temp[i+1],
                               shadow_visc[i], shadow_temp[i], v);
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic flag_mismatch(input string msg);
      if (mismatches < 10) begin
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      end
      mismatches++;
   endtask

   // Driver: each word waits a drawn gap, and a marked word waits until
   // every outstanding result has come back.
   always @(posedge clock) begin
      int unsigned     gap;
      rsp_word_type    want;
      logic            free;
      queued_word_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
         idle_left <= 0;
      end else begin
         gap = idle_left;
         free = !req_valid || !req_stall;
         if (req_valid && !req_stall) begin
            want = predict_lookup(req_word);
            expected_results.push_back(want);
            kind_count[req_word.kind]++;
            status_count[want.status]++;
            if (tx_quiet > 0) begin
               tx_quiet--;
            end else if ($urandom_range(0, 24) == 0) begin
               tx_quiet = $urandom_range(10, 40);
            end
            gap = (tx_quiet > 0) ? 0 : $urandom_range(0, 8);
         end
         if (free) begin
            if (gap == 0 && queued_words.size() > 0 &&
                !(queued_words[0].wait_empty && expected_results.size() != 0)) begin
               next_item = queued_words.pop_front();
               req_valid <= 1'b1;
               req_word <= next_item.word;
            end else begin
               req_valid <= 1'b0;
               if (gap > 0) begin
                  gap--;
               end
            end
         end
         idle_left <= gap;
      end
   end

   // Result side back-pressure: a drawn stall per word, plus long holds on request.
   always @(posedge clock) begin
      int unsigned s;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         s = stall_left;
         if (hold_done != hold_asked) begin
            s = LONG_HOLD;
            hold_done <= hold_asked;
         end else if (rsp_valid && !rsp_stall) begin
            if (rx_quiet > 0) begin
               rx_quiet--;
            end else if ($urandom_range(0, 24) == 0) begin
               rx_quiet = $urandom_range(10, 40);
            end
            s = (rx_quiet > 0) ? 0 : $urandom_range(0, 8);
         end else if (s > 0) begin
            s--;
         end
         rsp_stall <= (s > 0);
         stall_left <= s;
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (expected_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result word, value_out %0d status %0d",
                                    rsp_word.value_out, rsp_word.status));
         end else begin
            want = expected_results.pop_front();
            if (rsp_word.value_out !== want.value_out) begin
               flag_mismatch($sformatf("result %0d value_out: expected %0d, got %0d",
                                       results_checked, want.value_out,
                                       rsp_word.value_out));
            end
            if (rsp_word.status !== want.status) begin
               flag_mismatch($sformatf("result %0d status: expected %0d, got %0d",
                                       results_checked, want.status, rsp_word.status));
            end
         end
      end
   end

   function automatic req_word_type make_word(input logic [1:0] k, input int idx,
                                              input int t, input int v);
      req_word_type w;
      w.kind = k;
      w.point_index = idx[3:0];
      w.temperature_in = t[15:0];
      w.viscosity_in = v[15:0];
      return w;
   endfunction

   task automatic push_word(input req_word_type w, input bit wait_empty);
      queued_word_type q;
      q.word = w;
      q.wait_empty = wait_empty;
      queued_words.push_back(q);
      if (w.kind == KIND_LOAD) begin
         aim_temp[w.point_index] = $signed(w.temperature_in);
         aim_visc[w.point_index] = $signed(w.viscosity_in);
      end
   endtask

   // Operands mostly land near a breakpoint so that every segment is visited.
   function automatic req_word_type random_word();
      req_word_type w;
      int           pick, j, near_t, near_v;
      w = make_word(KIND_FORWARD, $urandom_range(0, 15), $urandom, $urandom);
      pick = $urandom_range(0, 99);
      j = $urandom_range(0, TABLE_POINTS - 1);
      near_t = aim_temp[j] + $urandom_range(0, 600) - 300;
      near_v = aim_visc[j] + $urandom_range(0, 600) - 300;
      if ($urandom_range(0, 9) < 6) begin
         w.temperature_in = near_t[15:0];
         w.viscosity_in = near_v[15:0];
      end
      if (pick < 12) begin
         w.kind = KIND_LOAD;
      end else if (pick < 52) begin
         w.kind = KIND_FORWARD;
      end else if (pick < 95) begin
         w.kind = KIND_INVERSE;
      end else begin
         w.kind = KIND_UNUSED;
      end
      return w;
   endfunction

   // Rising temperatures against falling viscosities, with an occasional flat step.
   task automatic push_ordered_table();
      int tv, vv;
      tv = -$urandom_range(0, 20000);
      vv = $urandom_range(0, 20000);
      for (int i = 0; i < TABLE_POINTS; i++) begin
         push_word(make_word(KIND_LOAD, i, tv, vv), 1'b0);
         tv += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 900);
         vv -= ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 800);
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (queued_words.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [PADDR_WIDTH-1:0] addr,
                             input logic [PDATA_WIDTH-1:0] wdata,
                             output logic [PDATA_WIDTH-1:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= addr;
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (write && addr == ADDR_POINTS_IN_USE) begin
         shadow_in_use = wdata[CFG_WIDTH-1:0];
      end
   endtask

   task automatic set_points_in_use(input int count);
      logic [PDATA_WIDTH-1:0] data, back;
      data = ($urandom & ~32'h1f) | count;
      csr_access(1'b1, ADDR_POINTS_IN_USE, data, back);
      csr_access(1'b0, ADDR_POINTS_IN_USE, '0, back);
      if (back !== PDATA_WIDTH'(data[CFG_WIDTH-1:0])) begin
         flag_mismatch($sformatf("points_in_use readback: expected %0d, got %0d",
                                 data[CFG_WIDTH-1:0], back));
      end
   endtask

   initial begin
      logic [PDATA_WIDTH-1:0] scratch;
      for (int i = 0; i < TABLE_POINTS; i++) begin
         shadow_temp[i] = (i < DEFAULT_POINTS) ? 16'(3840 + 256 * i) : '0;
         shadow_visc[i] = (i < DEFAULT_POINTS) ? DEFAULT_VISC[16*i +: 16] : '0;
         aim_temp[i] = $signed(shadow_temp[i]);
         aim_visc[i] = $signed(shadow_visc[i]);
      end
      shadow_in_use = RESET_IN_USE;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset table and count: exact points, inner points and both extremes.
      push_word(make_word(KIND_FORWARD, 0, 3840, 0), 1'b0);
      push_word(make_word(KIND_FORWARD, 5, 4000, 0), 1'b0);
      push_word(make_word(KIND_FORWARD, 0, -32768, 32767), 1'b0);
      push_word(make_word(KIND_FORWARD, 15, 32767, -32768), 1'b0);
      push_word(make_word(KIND_FORWARD, 0, 7168, 0), 1'b0);
      push_word(make_word(KIND_INVERSE, 0, 0, 4669), 1'b0);
      push_word(make_word(KIND_INVERSE, 0, 0, 4000), 1'b0);
      push_word(make_word(KIND_INVERSE, 0, 32767, -32768), 1'b0);
      push_word(make_word(KIND_INVERSE, 0, -32768, 32767), 1'b0);
      push_word(make_word(KIND_INVERSE, 0, 0, 3437), 1'b0);
      push_word(make_word(KIND_UNUSED, 15, -1, -1), 1'b0);
      // Entries past the points in use must not disturb queries.
      push_word(make_word(KIND_LOAD, 15, 32767, -32768), 1'b0);
      push_word(make_word(KIND_LOAD, 14, -32768, 32767), 1'b0);
      push_word(make_word(KIND_FORWARD, 0, 32767, 0), 1'b0);
      // Equal temperatures make the first segment flat.
      push_word(make_word(KIND_LOAD, 1, 3840, 4547), 1'b0);
      push_word(make_word(KIND_FORWARD, 0, 3000, 0), 1'b0);
      // A one-LSB-wide steep segment drives the result past the low limit.
      push_word(make_word(KIND_LOAD, 1, 3841, 32767), 1'b0);
      push_word(make_word(KIND_FORWARD, 0, 3000, 0), 1'b1);
      push_word(make_word(KIND_LOAD, 1, 4096, 4547), 1'b0);
      // Equal viscosities make the last inverse segment flat.
      push_word(make_word(KIND_LOAD, 12, 6912, 3437), 1'b0);
      push_word(make_word(KIND_INVERSE, 0, 0, -32768), 1'b0);
      push_word(make_word(KIND_LOAD, 12, 6912, 3510), 1'b0);

      for (int p = 0; p < SETTING_COUNT; p++) begin
         wait_idle();
         set_points_in_use(point_settings[p]);
         if (p == 3) begin
            csr_access(1'b1, ADDR_UNMAPPED, $urandom, scratch);
         end
         if (p % 2 == 0) begin
            push_ordered_table();
         end
         for (int k = 0; k < WORDS_PER_SET; k++) begin
            push_word(random_word(), $urandom_range(0, 49) == 0);
         end
         // Hold the result side off so that the block backs up into req_stall.
         if (p == 0 || p == 5) begin
            hold_asked <= hold_asked + 1;
         end
      end

      wait_idle();
      repeat (50) @(posedge clock);
      $display("Ran %0d words: %0d loads, %0d forward, %0d inverse, %0d unused kind;",
               kind_count[KIND_LOAD] + kind_count[KIND_FORWARD] + kind_count[KIND_INVERSE]
               + kind_count[KIND_UNUSED], kind_count[KIND_LOAD], kind_count[KIND_FORWARD],
               kind_count[KIND_INVERSE], kind_count[KIND_UNUSED]);
      $display(
         "%0d results checked (%0d saturated, %0d flat) over %0d counts, %0d mismatches.",
         results_checked, status_count[STS_SATURATED], status_count[STS_FLAT],
         SETTING_COUNT + 1, mismatches);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("** table_linear_interpolator: PASSED **");
      end else begin
         $display("** table_linear_interpolator: FAILED **");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/tli_pkg.sv
sv/tli_div.sv
sv/tli_dpath.sv
sv/tli_ctrl.sv
sv/table_linear_interpolator.sv
sv/tli_chk.sv
verif/tb.sv
